// ----- hdl/sparse_coo_matrix_multiply_macros.svh -----
// assertion macros used by the rtl controller scm_ctrl
`ifndef SPARSE_COO_MATRIX_MULTIPLY_MACROS_SVH
`define SPARSE_COO_MATRIX_MULTIPLY_MACROS_SVH

// assert that a implies b in the same cycle
`define SCM_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// assert that a implies b in the next cycle
`define SCM_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ----- hdl/scm_pkg.sv -----
// ----------------------------------------------------------------------------
// scm_pkg
// shared constants and types of the sparse coo multiplier
// ----------------------------------------------------------------------------
package scm_pkg;

  localparam int unsigned DefADepth    = 64;
  localparam int unsigned DefBDepth    = 64;
  localparam int unsigned DefCDepth    = 64;
  localparam int unsigned DefIndexBits = 10;
  localparam int unsigned FieldBits    = 10;
  localparam int unsigned ValueBits    = 32;

  typedef enum logic [1:0] {
    FUNC_LOAD_A  = 2'd0,
    FUNC_LOAD_B  = 2'd1,
    FUNC_COMPUTE = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

  // controller to datapath
  typedef struct packed {
    logic load_a;     // store input in a
    logic load_b;     // store input in b
    logic clr_job;    // clear counts and flag
    logic clr_table;  // start table empty
    logic rd_ab;      // read a[ai], b[bi]
    logic step_ab;    // advance pair indices
    logic pair_chk;   // evaluate read pair (registered)
    logic mul;        // register product
    logic srch_start; // begin table search
    logic srch_step;  // advance search index
    logic rd_c;       // read table entry at search index
    logic upd;        // write result of search
    logic emit_start; // reset emit index
    logic emit_rd;    // read table entry at emit index
    logic emit_load;  // load output register
    logic emit_step;  // advance emit index
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ab_done;    // all pairs visited
    logic pair_hit;   // registered pair matches
    logic srch_done;  // search index reached count
    logic srch_hit;   // read entry matches key
    logic emit_last;  // emit index at final entry
  } sts_t;

endpackage

// ----- hdl/scm_if.sv -----
// ----------------------------------------------------------------------------
// scm_in_if / scm_out_if
// valid-ready channels of the sparse coo multiplier
// ----------------------------------------------------------------------------
interface scm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [9:0]  row;
  logic [9:0]  col;
  logic signed [31:0] value;
  modport source (output valid, func, row, col, value, input ready);
  modport sink   (input valid, func, row, col, value, output ready);
endinterface

interface scm_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  out_row;
  logic [9:0]  out_col;
  logic signed [31:0] out_value;
  logic        last;
  logic        empty_res;
  logic        overflow;
  modport source (output valid, out_row, out_col, out_value, last, empty_res, overflow,
                  input ready);
  modport sink   (input valid, out_row, out_col, out_value, last, empty_res, overflow,
                  output ready);
endinterface

// ----- hdl/sparse_coo_matrix_multiply.sv -----
// ----------------------------------------------------------------------------
// sparse_coo_matrix_multiply
// sparse matrix product over coordinate triples
// ----------------------------------------------------------------------------
// Load items (func 0 or 1) are taken while idle and append an entry to the
// A or B store. A compute item (func 2) scans all stored pairs: each pair is
// read and checked, and a matching pair is multiplied and its key searched
// entry by entry in the table, then added to the match or appended. The table
// is then emitted in insertion order, each result waiting for the output
// register to be free, the final one marked last; an empty product gives one
// result with empty_res set. Input is not taken during a run.
module sparse_coo_matrix_multiply
  import scm_pkg::*;
#(
  parameter int unsigned A_DEPTH    = DefADepth,
  parameter int unsigned B_DEPTH    = DefBDepth,
  parameter int unsigned C_DEPTH    = DefCDepth,
  parameter int unsigned INDEX_BITS = DefIndexBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  scm_in_if.sink    in_if,
  scm_out_if.source out_if
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  scm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .func_i      (in_if.func),
    .in_ready_o  (in_if.ready),
    .out_valid_i (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // stores, arithmetic and output register
  scm_datapath #(
    .A_DEPTH    (A_DEPTH),
    .B_DEPTH    (B_DEPTH),
    .C_DEPTH    (C_DEPTH),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .row_i       (in_if.row),
    .col_i       (in_if.col),
    .value_i     (in_if.value),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .out_row_o   (out_if.out_row),
    .out_col_o   (out_if.out_col),
    .out_value_o (out_if.out_value),
    .out_last_o  (out_if.last),
    .out_empty_o (out_if.empty_res),
    .out_ovf_o   (out_if.overflow)
  );

endmodule

// ----- hdl/scm_datapath.sv -----
// ----------------------------------------------------------------------------
// scm_datapath
// entry stores, product table, multiplier and output register
// ----------------------------------------------------------------------------
module scm_datapath
  import scm_pkg::*;
#(
  parameter int unsigned A_DEPTH    = DefADepth,
  parameter int unsigned B_DEPTH    = DefBDepth,
  parameter int unsigned C_DEPTH    = DefCDepth,
  parameter int unsigned INDEX_BITS = DefIndexBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [9:0]  row_i,
  input  logic [9:0]  col_i,
  input  logic signed [31:0] value_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [9:0]  out_row_o,
  output logic [9:0]  out_col_o,
  output logic signed [31:0] out_value_o,
  output logic        out_last_o,
  output logic        out_empty_o,
  output logic        out_ovf_o
);

  localparam int unsigned AW  = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int unsigned BW  = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int unsigned CW  = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;
  localparam int unsigned ACW = $clog2(A_DEPTH + 1);
  localparam int unsigned BCW = $clog2(B_DEPTH + 1);
  localparam int unsigned CCW = $clog2(C_DEPTH + 1);
  localparam int unsigned EW  = 2 * INDEX_BITS + ValueBits;

  typedef logic [EW-1:0] ent_t;
  localparam logic signed [63:0] QMax = 64'sd2147483647;
  localparam logic signed [63:0] QMin = -64'sd2147483648;

  ent_t a_mem [A_DEPTH];
  ent_t b_mem [B_DEPTH];
  ent_t c_mem [C_DEPTH];

  logic [ACW-1:0] a_cnt_q;
  logic [BCW-1:0] b_cnt_q;
  logic [CCW-1:0] c_cnt_q;
  logic           drop_q;
  logic [ACW-1:0] ai_q;
  logic [BCW-1:0] bi_q;
  logic [CCW-1:0] si_q;
  ent_t           a_rd_q, b_rd_q, c_rd_q;
  logic           hit_q;
  logic [INDEX_BITS-1:0] key_r_q, key_c_q, key_r_d, key_c_d;
  logic signed [31:0] pa_q, pb_q;
  logic signed [31:0] prod_q;
  logic signed [63:0] mul_full;
  logic signed [47:0] mul_sh;

  logic [INDEX_BITS-1:0] ar, ac, br, bc, cr, cc;
  logic signed [31:0] av, bv, cv;
  assign {ar, ac, av} = a_rd_q;
  assign {br, bc, bv} = b_rd_q;
  assign {cr, cc, cv} = c_rd_q;

  logic [INDEX_BITS-1:0] in_r, in_c;
  assign in_r = INDEX_BITS'(row_i);
  assign in_c = INDEX_BITS'(col_i);

  function automatic logic signed [31:0] sat_q(logic signed [47:0] x);
    if (x > 48'(QMax)) return 32'sh7fffffff;
    if (x < 48'(QMin)) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] sat_add(logic signed [31:0] x,
                                                 logic signed [31:0] y);
    logic signed [32:0] s;
    s = {x[31], x} + {y[31], y};
    if (s[32] != s[31]) return s[32] ? 32'sh80000000 : 32'sh7fffffff;
    return s[31:0];
  endfunction

  // stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a && (a_cnt_q < ACW'(A_DEPTH)))
      a_mem[a_cnt_q[AW-1:0]] <= {in_r, in_c, value_i};
    if (cmd_i.load_b && (b_cnt_q < BCW'(B_DEPTH)))
      b_mem[b_cnt_q[BW-1:0]] <= {in_r, in_c, value_i};
    if (cmd_i.rd_ab) begin
      a_rd_q <= a_mem[ai_q[AW-1:0]];
      b_rd_q <= b_mem[bi_q[BW-1:0]];
    end
    if (cmd_i.rd_c) c_rd_q <= c_mem[si_q[CW-1:0]];
    else if (cmd_i.emit_rd) c_rd_q <= c_mem[si_q[CW-1:0]];
    if (cmd_i.upd) begin
      if (sts_o.srch_hit && !sts_o.srch_done)
        c_mem[si_q[CW-1:0]] <= {cr, cc, sat_add(cv, prod_q)};
      else if (c_cnt_q < CCW'(C_DEPTH))
        c_mem[c_cnt_q[CW-1:0]] <= {key_r_q, key_c_q, prod_q};
    end
    if (cmd_i.pair_chk) begin
      key_r_q <= key_r_d;
      key_c_q <= key_c_d;
      pa_q    <= av;
      pb_q    <= bv;
    end
    if (cmd_i.mul) prod_q <= sat_q(mul_sh);
  end

  assign key_r_d = ar;
  assign key_c_d = bc;
  assign mul_full = pa_q * pb_q;
  assign mul_sh   = mul_full[63:16];

  // counters and indices
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_cnt_q <= '0; b_cnt_q <= '0; c_cnt_q <= '0; drop_q <= 1'b0;
      ai_q <= '0; bi_q <= '0; si_q <= '0; hit_q <= 1'b0;
    end else begin
      if (cmd_i.load_a) begin
        if (a_cnt_q < ACW'(A_DEPTH)) a_cnt_q <= a_cnt_q + 1'b1;
        else drop_q <= 1'b1;
      end
      if (cmd_i.load_b) begin
        if (b_cnt_q < BCW'(B_DEPTH)) b_cnt_q <= b_cnt_q + 1'b1;
        else drop_q <= 1'b1;
      end
      if (cmd_i.clr_table) begin
        c_cnt_q <= '0; ai_q <= '0; bi_q <= '0;
      end
      if (cmd_i.step_ab) begin
        if (bi_q + 1'b1 >= b_cnt_q) begin
          bi_q <= '0;
          ai_q <= ai_q + 1'b1;
        end else bi_q <= bi_q + 1'b1;
      end
      if (cmd_i.pair_chk) hit_q <= (ac == br);
      if (cmd_i.srch_start || cmd_i.emit_start) si_q <= '0;
      if (cmd_i.srch_step || cmd_i.emit_step) si_q <= si_q + 1'b1;
      if (cmd_i.upd && !(sts_o.srch_hit && !sts_o.srch_done)) begin
        if (c_cnt_q < CCW'(C_DEPTH)) c_cnt_q <= c_cnt_q + 1'b1;
        else drop_q <= 1'b1;
      end
      if (cmd_i.clr_job) begin
        a_cnt_q <= '0; b_cnt_q <= '0; c_cnt_q <= '0; drop_q <= 1'b0;
      end
    end
  end

  assign sts_o.ab_done   = (ai_q >= a_cnt_q) || (b_cnt_q == '0);
  assign sts_o.pair_hit  = hit_q;
  assign sts_o.srch_done = (si_q >= c_cnt_q);
  assign sts_o.srch_hit  = (cr == key_r_q) && (cc == key_c_q);
  assign sts_o.emit_last = (si_q + 1'b1 >= c_cnt_q);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (cmd_i.emit_load) out_valid_o <= 1'b1;
    else if (out_ready_i) out_valid_o <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_ovf_o <= drop_q;
      if (c_cnt_q == '0) begin
        out_row_o <= '0; out_col_o <= '0; out_value_o <= '0;
        out_last_o <= 1'b1; out_empty_o <= 1'b1;
      end else begin
        out_row_o   <= 10'(cr);
        out_col_o   <= 10'(cc);
        out_value_o <= cv;
        out_last_o  <= sts_o.emit_last;
        out_empty_o <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/scm_ctrl.sv -----
// ----------------------------------------------------------------------------
// scm_ctrl
// sequencer of load, pair scan, table search and emit
// ----------------------------------------------------------------------------
`include "sparse_coo_matrix_multiply_macros.svh"
module scm_ctrl
  import scm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] func_i,
  output logic       in_ready_o,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_RDAB  = 11'b00000000010,
    S_PAIR  = 11'b00000000100,
    S_CHK   = 11'b00000001000,
    S_MUL   = 11'b00000010000,
    S_SRD   = 11'b00000100000,
    S_SCMP  = 11'b00001000000,
    S_ERD   = 11'b00010000000,
    S_ELD   = 11'b00100000000,
    S_EWAIT = 11'b01000000000,
    S_CLR   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic   acc;

  assign in_ready_o = (state_q == S_IDLE);
  assign acc = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (func_i)
            FUNC_LOAD_A:  cmd_o.load_a = 1'b1;
            FUNC_LOAD_B:  cmd_o.load_b = 1'b1;
            FUNC_COMPUTE: begin
              cmd_o.clr_table = 1'b1;
              state_d = S_RDAB;
            end
            default: ;
          endcase
        end
      end
      S_RDAB: begin
        if (sts_i.ab_done) begin
          cmd_o.emit_start = 1'b1;
          state_d = S_ERD;
        end else begin
          cmd_o.rd_ab = 1'b1;
          cmd_o.step_ab = 1'b1;
          state_d = S_PAIR;
        end
      end
      S_PAIR: begin
        cmd_o.pair_chk = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (sts_i.pair_hit) begin
          cmd_o.mul = 1'b1;
          cmd_o.srch_start = 1'b1;
          state_d = S_MUL;
        end else state_d = S_RDAB;
      end
      S_MUL, S_SRD: begin
        if (sts_i.srch_done) begin
          cmd_o.upd = 1'b1;
          state_d = S_RDAB;
        end else begin
          cmd_o.rd_c = 1'b1;
          state_d = S_SCMP;
        end
      end
      S_SCMP: begin
        if (sts_i.srch_hit) begin
          cmd_o.upd = 1'b1;
          state_d = S_RDAB;
        end else begin
          cmd_o.srch_step = 1'b1;
          state_d = S_SRD;
        end
      end
      S_ERD: begin
        cmd_o.emit_rd = 1'b1;
        state_d = S_ELD;
      end
      S_ELD: begin
        if (!out_valid_i || out_ready_i) begin
          cmd_o.emit_load = 1'b1;
          if (sts_i.emit_last) state_d = S_CLR;
          else begin
            cmd_o.emit_step = 1'b1;
            state_d = S_EWAIT;
          end
        end
      end
      S_EWAIT: state_d = S_ERD;
      S_CLR: begin
        cmd_o.clr_job = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  `SCM_ASSERT_IMP(a_load_idle, clk_i, rst_ni, cmd_o.load_a || cmd_o.load_b, state_q == S_IDLE)
  `SCM_ASSERT_IMP(a_emit_room, clk_i, rst_ni, cmd_o.emit_load, !out_valid_i || out_ready_i)
  `SCM_ASSERT_NEXT(a_clr_idle, clk_i, rst_ni, cmd_o.clr_job, state_q == S_IDLE)

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sparse coo multiplier: loads and computes are
// queued, a software model predicts each emitted entry, a monitor compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import scm_pkg::*;

  localparam int unsigned Depth = 64;
  localparam int unsigned WatchLimit = 3000000;

  typedef struct packed {
    func_e       func;
    logic [9:0]  row;
    logic [9:0]  col;
    logic [31:0] value;
  } job_item_t;

  typedef struct packed {
    logic [9:0]  row;
    logic [9:0]  col;
    logic [31:0] value;
    logic        last;
    logic        empty_res;
    logic        overflow;
  } entry_t;

  typedef struct {
    logic [9:0]         r;
    logic [9:0]         c;
    logic signed [31:0] v;
  } triple_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  scm_in_if  in_if ();
  scm_out_if out_if ();

  sparse_coo_matrix_multiply DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if.sink),
    .out_if(out_if.source)
  );

  always #2 clk_i = ~clk_i;

  // model state
  triple_t a_mat[Depth];
  triple_t b_mat[Depth];
  triple_t c_tab[Depth];
  int unsigned a_num, b_num, c_num;
  bit dropped;

  job_item_t pending_items[$];
  entry_t    expected_entries[$];
  int        err_count = 0;
  bit        stim_done = 1'b0;
  bit        hold_sender = 1'b0;
  bit        long_stall = 1'b0;
  int        idle_cycles = 0;

  function automatic logic signed [31:0] sat_q(logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'h7fffffff;
    if (x < -64'sd2147483648) return 32'h80000000;
    return x[31:0];
  endfunction

  // q16.16 product, floor on the dropped bits
  function automatic logic signed [31:0] q_mul(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return sat_q(p >>> 16);
  endfunction

  function automatic void add_product(logic [9:0] r, logic [9:0] c, logic signed [31:0] v);
    for (int n = 0; n < c_num; n++) begin
      if (c_tab[n].r == r && c_tab[n].c == c) begin
        c_tab[n].v = sat_q(64'(c_tab[n].v) + 64'(v));
        return;
      end
    end
    if (c_num < Depth) begin
      c_tab[c_num] = '{r, c, v};
      c_num++;
    end else begin
      dropped = 1'b1;
    end
  endfunction

  // apply one accepted transfer to the model, push predicted entries
  function automatic void predict_product(job_item_t it);
    entry_t e;
    case (it.func)
      FUNC_LOAD_A: begin
        if (a_num < Depth) begin
          a_mat[a_num] = '{it.row, it.col, it.value}; a_num++;
        end else dropped = 1'b1;
      end
      FUNC_LOAD_B: begin
        if (b_num < Depth) begin
          b_mat[b_num] = '{it.row, it.col, it.value}; b_num++;
        end else dropped = 1'b1;
      end
      FUNC_COMPUTE: begin
        c_num = 0;
        for (int a = 0; a < a_num; a++)
          for (int b = 0; b < b_num; b++)
            if (a_mat[a].c == b_mat[b].r)
              add_product(a_mat[a].r, b_mat[b].c, q_mul(a_mat[a].v, b_mat[b].v));
        if (c_num == 0) begin
          e = '{10'd0, 10'd0, 32'd0, 1'b1, 1'b1, dropped};
          expected_entries.push_back(e);
        end else begin
          for (int n = 0; n < c_num; n++) begin
            e = '{c_tab[n].r, c_tab[n].c, c_tab[n].v, (n + 1 == c_num), 1'b0, dropped};
            expected_entries.push_back(e);
          end
        end
        a_num = 0; b_num = 0; c_num = 0; dropped = 1'b0;
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    err_count++;
  endtask

  // driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.func  <= FUNC_NONE;
      in_if.row   <= '0;
      in_if.col   <= '0;
      in_if.value <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_product(pending_items.pop_front());
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (gap_left > 0) gap_left--;
        if (pending_items.size() != 0 && !hold_sender && gap_left == 0) begin
          in_if.valid <= 1'b1;
          in_if.func  <= pending_items[0].func;
          in_if.row   <= pending_items[0].row;
          in_if.col   <= pending_items[0].col;
          in_if.value <= pending_items[0].value;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
          end
          burst_left--;
          if (burst_left == 0 && ($urandom_range(0, 2) != 0)) gap_left = $urandom_range(1, 6);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // note: the item on the bus is pending_items[0] until accepted

  // receiver stall pattern
  int stall_phase = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      stall_phase <= (stall_phase + 1) % 37;
      if (long_stall) out_if.ready <= 1'b0;
      else if (stall_phase < 12) out_if.ready <= 1'b1;
      else out_if.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    entry_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_entries.size() == 0) begin
        $display("unexpected result row %0d col %0d", out_if.out_row, out_if.out_col);
        err_count++;
      end else begin
        want = expected_entries.pop_front();
        if (out_if.out_row !== want.row)
          report_mismatch("row", 32'(out_if.out_row), 32'(want.row));
        if (out_if.out_col !== want.col)
          report_mismatch("col", 32'(out_if.out_col), 32'(want.col));
        if (out_if.out_value !== want.value)
          report_mismatch("value", out_if.out_value, want.value);
        if (out_if.last !== want.last)
          report_mismatch("last", 32'(out_if.last), 32'(want.last));
        if (out_if.empty_res !== want.empty_res)
          report_mismatch("empty_res", 32'(out_if.empty_res), 32'(want.empty_res));
        if (out_if.overflow !== want.overflow)
          report_mismatch("overflow", 32'(out_if.overflow), 32'(want.overflow));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || long_stall ||
        (pending_items.size() == 0 && expected_entries.size() == 0))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void queue_item(func_e f, logic [9:0] r, logic [9:0] c, logic [31:0] v);
    job_item_t it;
    it.func = f; it.row = r; it.col = c; it.value = v;
    pending_items.push_back(it);
  endfunction

  // one well-formed job with small indices so rows and columns meet
  function automatic void queue_job(int na, int nb, int span);
    for (int k = 0; k < na; k++)
      queue_item(FUNC_LOAD_A, 10'($urandom_range(0, span)), 10'($urandom_range(0, span)),
                 $urandom());
    for (int k = 0; k < nb; k++)
      queue_item(FUNC_LOAD_B, 10'($urandom_range(0, span)), 10'($urandom_range(0, span)),
                 ($urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h3ffff)));
    queue_item(FUNC_COMPUTE, 10'($urandom()), 10'($urandom()), $urandom());
  endfunction

  initial begin
    int sent;
    a_num = 0; b_num = 0; c_num = 0; dropped = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty product, extremes, saturation, accumulation, func 3
    queue_item(FUNC_COMPUTE, '0, '0, '0);
    queue_item(FUNC_LOAD_A, 10'h3ff, 10'h3ff, 32'h7fffffff);
    queue_item(FUNC_LOAD_B, 10'h3ff, 10'h3ff, 32'h7fffffff);
    queue_item(FUNC_LOAD_A, 10'h3ff, 10'h3ff, 32'h80000000);
    queue_item(FUNC_LOAD_B, 10'h3ff, 10'h000, 32'h80000000);
    queue_item(FUNC_NONE, 10'h155, 10'h2aa, 32'h12345678);
    queue_item(FUNC_COMPUTE, '0, '0, '0);
    queue_item(FUNC_LOAD_A, 10'd1, 10'd2, 32'hffff0000);
    queue_item(FUNC_LOAD_A, 10'd1, 10'd3, 32'h00018000);
    queue_item(FUNC_LOAD_B, 10'd2, 10'd5, 32'hffffffff);
    queue_item(FUNC_LOAD_B, 10'd3, 10'd5, 32'h00000003);
    queue_item(FUNC_LOAD_B, 10'd7, 10'd5, 32'h00010000);
    queue_item(FUNC_COMPUTE, '0, '0, '0);
    // loads with no matching pair
    queue_item(FUNC_LOAD_A, 10'd0, 10'd1, 32'h1);
    queue_item(FUNC_LOAD_B, 10'd2, 10'd0, 32'h1);
    queue_item(FUNC_COMPUTE, '0, '0, '0);

    // full a store and full table: 65 a loads, 128 distinct keys wanted
    for (int k = 0; k <= Depth; k++) queue_item(FUNC_LOAD_A, k[9:0], 10'd0, 32'h10000);
    for (int k = 0; k < 2; k++) queue_item(FUNC_LOAD_B, 10'd0, k[9:0], 32'h10000);
    queue_item(FUNC_LOAD_B, 10'd0, 10'd0, 32'h10000);
    queue_item(FUNC_COMPUTE, '0, '0, '0);

    // long receiver hold while the sender keeps offering
    queue_job(8, 8, 3);
    queue_job(4, 4, 2);
    for (int k = 0; k < 6; k++)
      queue_item(FUNC_LOAD_A, 10'($urandom()), 10'($urandom()), $urandom());
    long_stall = 1'b1;
    repeat (3000) @(posedge clk_i);
    long_stall = 1'b0;

    // sender pauses until everything has drained
    wait (pending_items.size() == 0);
    hold_sender = 1'b1;
    wait (expected_entries.size() == 0);
    hold_sender = 1'b0;

    // random jobs, mostly well formed
    sent = 0;
    while (sent < 20) begin
      if ($urandom_range(0, 5) == 0) begin
        queue_item(func_e'($urandom_range(0, 3)), 10'($urandom()), 10'($urandom()),
                   $urandom());
        sent++;
      end else begin
        int na, nb;
        na = $urandom_range(0, 8);
        nb = $urandom_range(0, 8);
        queue_job(na, nb, $urandom_range(1, 6));
        sent += na + nb + 1;
      end
      wait (pending_items.size() < 20);
    end
    queue_item(FUNC_COMPUTE, '0, '0, '0);

    wait (pending_items.size() == 0 && expected_entries.size() == 0);
    repeat (200) @(posedge clk_i);
    if (err_count == 0 && expected_entries.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
